// ===== src/led_breathe_blink_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// led breathe blink sequencer assertion macros
// concurrent check helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LED_BREATHE_BLINK_SEQUENCER_MACROS_SVH
`define LED_BREATHE_BLINK_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbb assertion failed");

// next-cycle implication
`define LBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbb assertion failed");

`else

`define LBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LBB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lbb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_pkg
// shared types and constants of the led breathe blink sequencer
// ----------------------------------------------------------------------------
package lbb_pkg;

    localparam int DUR_W    = 16;
    localparam int LVL_W    = 8;
    localparam int BLINK_W  = 8;
    localparam int IDX_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int NUM_W    = DUR_W + LVL_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHT = 3'd5;

    localparam logic [DUR_W-1:0]   FADE_TIME_RST  = 16'd500;
    localparam logic [DUR_W-1:0]   ON_TIME_RST    = 16'd500;
    localparam logic [DUR_W-1:0]   OFF_TIME_RST   = 16'd500;
    localparam logic [BLINK_W-1:0] BLINKS_RST     = 8'd1;
    localparam logic [IDX_W-1:0]   JUMP_RST       = 10'd1;
    localparam logic [LVL_W-1:0]   MAX_BRIGHT_RST = 8'd240;

    typedef enum logic [1:0] {
        PH_FADE_UP   = 2'd0,
        PH_ON        = 2'd1,
        PH_FADE_DOWN = 2'd2,
        PH_OFF       = 2'd3
    } phase_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } lbb_cmd_t;

    typedef struct packed {
        logic div_done;
    } lbb_sts_t;

endpackage

`default_nettype wire

// ===== src/led_breathe_blink_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_breathe_blink_sequencer
// Breathing and blinking led pattern sequencer. Each input beat is a tick
// carrying elapsed time; each tick yields one output beat with the brightness
// of the current phase, the strip start offset, the phase and a strip clear
// flag. A tick occupies the block from acceptance to the next possible
// acceptance: a capture state, a multiply state, 24 steps of the bit-serial
// restoring divider and a state update. The result sits in an output
// register, so the next tick is taken while it waits; commit stalls only if
// the previous result is still not taken. Config writes are always ready and
// must be issued while no tick is in flight.
// ----------------------------------------------------------------------------
`include "led_breathe_blink_sequencer_macros.svh"

module led_breathe_blink_sequencer
    import lbb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [DUR_W-1:0]     elapsed,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [LVL_W-1:0]     brightness,
    output logic      [IDX_W-1:0]     start_pixel,
    output logic      [1:0]           phase,
    output logic                      clear_strip,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    lbb_cmd_t cmd;
    lbb_sts_t sts;

    assign cfg_ready = 1'b1;

    lbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lbb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .elapsed     (elapsed),
        .brightness  (brightness),
        .start_pixel (start_pixel),
        .phase       (phase),
        .clear_strip (clear_strip)
    );

    // one tick at a time
    `LBB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // clear only at the end of a dark phase
    `LBB_ASSERT_IMPLY(a_clear_in_off, clk, rst_n, out_valid && clear_strip, phase == PH_OFF)
    // dark phase is always black
    `LBB_ASSERT_IMPLY(a_off_dark, clk, rst_n, out_valid && phase == PH_OFF, brightness == '0)

endmodule

`default_nettype wire

// ===== src/lbb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_datapath
// config registers, sequencer state, multiplier and restoring divider
// ----------------------------------------------------------------------------
module lbb_datapath
    import lbb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lbb_cmd_t              cmd,
    output lbb_sts_t                   sts,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data,
    input  wire logic [DUR_W-1:0]      elapsed,
    output logic      [LVL_W-1:0]      brightness,
    output logic      [IDX_W-1:0]      start_pixel,
    output logic      [1:0]            phase,
    output logic                       clear_strip
);

    logic [DUR_W-1:0]     fade_time_reg;
    logic [DUR_W-1:0]     on_time_reg;
    logic [DUR_W-1:0]     off_time_reg;
    logic [BLINK_W-1:0]   blinks_reg;
    logic [IDX_W-1:0]     jump_reg;
    logic [LVL_W-1:0]     max_bright_reg;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic                 dir_reg;
    logic                 dir_next;
    logic                 first_reg;
    logic [DUR_W-1:0]     countdown_reg;
    logic [DUR_W-1:0]     countdown_next;
    logic [BLINK_W-1:0]   blink_reg;
    logic [BLINK_W-1:0]   blink_next;

    logic [DUR_W-1:0]     elapsed_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DUR_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [LVL_W-1:0]     bright_out_reg;
    logic [IDX_W-1:0]     start_out_reg;
    logic [1:0]           phase_out_reg;
    logic                 clear_out_reg;

    logic [DUR_W-1:0]     mul_a;
    logic [NUM_W-1:0]     product;
    logic [DUR_W:0]       rem_sh;
    logic [DUR_W+1:0]     diff;
    logic                 ge;
    logic [LVL_W-1:0]     quot_clamp;
    logic [LVL_W-1:0]     level;
    logic [DUR_W-1:0]     cd_load;
    logic                 clr;
    logic [BLINK_W:0]     blink_inc;

    // multiplier operand and product
    assign mul_a   = (phase_reg == PH_FADE_UP) ? (fade_time_reg - countdown_reg)
                                               : countdown_reg;
    assign product = NUM_W'(mul_a) * NUM_W'(max_bright_reg);

    // restoring divider step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, fade_time_reg};
    assign ge     = !diff[DUR_W+1];

    assign sts.div_done = (cnt_reg == DIV_CNT_W'(NUM_W - 1));

    // brightness before update
    assign quot_clamp = (num_reg > NUM_W'(max_bright_reg)) ? max_bright_reg
                                                            : num_reg[LVL_W-1:0];

    always_comb
    begin
        level = quot_clamp;
        if (first_reg)
        begin
            level = max_bright_reg;
        end
        else
        begin
            case (phase_reg)
                PH_ON:
                begin
                    level = max_bright_reg;
                end
                PH_OFF:
                begin
                    level = '0;
                end
                PH_FADE_UP:
                begin
                    if (fade_time_reg == '0)
                    begin
                        level = max_bright_reg;
                    end
                    else if (countdown_reg > fade_time_reg)
                    begin
                        level = '0;
                    end
                end
                default:
                begin
                    if (fade_time_reg == '0)
                    begin
                        level = '0;
                    end
                end
            endcase
        end
    end

    // state update
    always_comb
    begin
        phase_next = phase_reg;
        dir_next   = dir_reg;
        blink_next = blink_reg;
        cd_load    = countdown_reg;
        clr        = 1'b0;
        blink_inc  = {1'b0, blink_reg} + 9'd1;
        if (first_reg)
        begin
            cd_load = fade_time_reg;
        end
        else if (countdown_reg == '0)
        begin
            case (phase_reg)
                PH_FADE_UP:
                begin
                    phase_next = PH_ON;
                    cd_load    = on_time_reg;
                end
                PH_ON:
                begin
                    phase_next = PH_FADE_DOWN;
                    cd_load    = fade_time_reg;
                end
                PH_FADE_DOWN:
                begin
                    phase_next = PH_OFF;
                    cd_load    = off_time_reg;
                end
                default:
                begin
                    phase_next = PH_FADE_UP;
                    cd_load    = fade_time_reg;
                    clr        = 1'b1;
                    if (blink_inc >= {1'b0, blinks_reg})
                    begin
                        blink_next = '0;
                        dir_next   = !dir_reg;
                    end
                    else
                    begin
                        blink_next = blink_inc[BLINK_W-1:0];
                    end
                end
            endcase
        end
        countdown_next = (cd_load > elapsed_reg) ? (cd_load - elapsed_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_time_reg  <= FADE_TIME_RST;
            on_time_reg    <= ON_TIME_RST;
            off_time_reg   <= OFF_TIME_RST;
            blinks_reg     <= BLINKS_RST;
            jump_reg       <= JUMP_RST;
            max_bright_reg <= MAX_BRIGHT_RST;
            phase_reg      <= PH_FADE_UP;
            dir_reg        <= 1'b0;
            first_reg      <= 1'b1;
            countdown_reg  <= '0;
            blink_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FADE_TIME:  fade_time_reg  <= cfg_data;
                    CFG_ON_TIME:    on_time_reg    <= cfg_data;
                    CFG_OFF_TIME:   off_time_reg   <= cfg_data;
                    CFG_BLINKS:     blinks_reg     <= cfg_data[BLINK_W-1:0];
                    CFG_JUMP:       jump_reg       <= cfg_data[IDX_W-1:0];
                    CFG_MAX_BRIGHT: max_bright_reg <= cfg_data[LVL_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.commit)
            begin
                phase_reg     <= phase_next;
                dir_reg       <= dir_next;
                first_reg     <= 1'b0;
                countdown_reg <= countdown_next;
                blink_reg     <= blink_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            elapsed_reg <= elapsed;
        end
        if (cmd.mul)
        begin
            num_reg <= product;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DUR_W-1:0] : rem_sh[DUR_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            bright_out_reg <= level;
            start_out_reg  <= dir_reg ? jump_reg : '0;
            phase_out_reg  <= phase_reg;
            clear_out_reg  <= clr;
        end
    end

    assign brightness  = bright_out_reg;
    assign start_pixel = start_out_reg;
    assign phase       = phase_out_reg;
    assign clear_strip = clear_out_reg;

endmodule

`default_nettype wire

// ===== src/lbb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_ctrl
// tick sequencing: capture, multiply, divide, commit and result handshake
// ----------------------------------------------------------------------------
module lbb_ctrl
    import lbb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output lbb_cmd_t      cmd,
    input  wire lbb_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
